[sv/stable_ordered_slot_queue_macros.svh]
// assertion macros for the stable ordered slot queue
`ifndef STABLE_ORDERED_SLOT_QUEUE_MACROS_SVH
`define STABLE_ORDERED_SLOT_QUEUE_MACROS_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define SOSQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define SOSQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/sosq_pkg.sv]
// shared types and constants for the stable ordered slot queue
`timescale 1ns / 1ps

package sosq_pkg;

    localparam int POOL_SLOTS_DEF   = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int KEY_W      = 32;
    localparam int IN_PAY_W   = 32;
    localparam int SLOT_W     = 4;
    localparam int COUNT_W    = 5;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 80;

    typedef enum logic [1:0] {
        FUNC_PUSH    = 2'd0,
        FUNC_POP     = 2'd1,
        FUNC_DROP    = 2'd2,
        FUNC_REORDER = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_PREP_RD,
        ST_UNL_WALK,
        ST_AFTER_UNL,
        ST_INS_WALK,
        ST_LINK_NEW,
        ST_LINK_PREV,
        ST_POP_RD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_in;
        logic rd_head;
        logic addr_slot;
        logic scan_start;
        logic ins_start;
        logic ins_step;
        logic unl_start;
        logic unl_step;
        logic save_link;
        logic head_skip;
        logic link_new;
        logic link_prev;
        logic pop_take;
        logic alloc;
        logic set_free;
        logic set_ok;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  head_empty;
        logic  full;
        logic  slot_ok;
        logic  key_same;
        logic  head_is_tgt;
        logic  prev_none;
        logic  walk_done;
        logic  unl_done;
        logic  free_found;
        logic  out_free;
    } sts_t;

endpackage

[sv/sosq_datapath.sv]
// slot memories, list pointers, walk registers and result register
`timescale 1ns / 1ps

module sosq_datapath #(
    parameter int POOL_SLOTS   = sosq_pkg::POOL_SLOTS_DEF,
    parameter int PAYLOAD_BITS = sosq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  sosq_pkg::cmd_t                   cmd,
    output sosq_pkg::sts_t                   sts,
    input  logic [sosq_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sosq_pkg::M_TDATA_W-1:0]   m_tdata
);
    import sosq_pkg::*;

    localparam int AW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int SW = $clog2(POOL_SLOTS + 1);
    localparam logic [SW-1:0] MARK = SW'(POOL_SLOTS);

    function automatic logic [AW-1:0] to_idx(input logic [SW-1:0] v);
        to_idx = (v < MARK) ? v[AW-1:0] : '0;
    endfunction

    logic [KEY_W-1:0]        key_mem  [POOL_SLOTS];
    logic [PAYLOAD_BITS-1:0] pay_mem  [POOL_SLOTS];
    logic [SW-1:0]           link_mem [POOL_SLOTS];

    logic [KEY_W-1:0]        rd_key_reg;
    logic [PAYLOAD_BITS-1:0] rd_pay_reg;
    logic [SW-1:0]           rd_link_reg;

    func_t                   func_reg;
    logic [KEY_W-1:0]        key_in_reg;
    logic [PAYLOAD_BITS-1:0] pay_in_reg;
    logic [SLOT_W-1:0]       slot_in_reg;
    logic [AW-1:0]           tgt_reg;
    logic [SW-1:0]           head_reg;
    logic [SW-1:0]           count_reg;
    logic [POOL_SLOTS-1:0]   active_reg;
    logic [SW-1:0]           cur_reg;
    logic [SW-1:0]           prev_reg;
    logic [SW-1:0]           link_s_reg;
    logic                    walk_done_reg;
    logic                    unl_done_reg;
    logic                    free_found_reg;
    logic [AW-1:0]           scan_reg;
    logic                    res_ok_reg;
    logic [AW-1:0]           res_slot_reg;
    logic [KEY_W-1:0]        res_key_reg;
    logic [PAYLOAD_BITS-1:0] res_pay_reg;
    logic                    out_valid_reg;
    logic [M_TDATA_W-1:0]    out_data_reg;

    logic [63:0]             pay_wide;
    logic [63:0]             res_pay_wide;
    logic [AW-1:0]           head_idx;
    logic [AW-1:0]           rd_addr;
    logic                    ins_adv;
    logic                    ins_stop;
    logic                    unl_live;
    logic                    unl_hit;
    logic                    unl_adv;
    logic                    link_we;
    logic [AW-1:0]           link_wa;
    logic [SW-1:0]           link_wd;
    logic                    slot_in_range;

    assign pay_wide      = {32'b0, s_tdata[65:34]};
    assign res_pay_wide  = 64'(res_pay_reg);
    assign head_idx      = to_idx(head_reg);
    assign slot_in_range = 32'(slot_in_reg) < POOL_SLOTS;

    // insertion walk: step past every entry whose key is not above the new one
    assign ins_adv  = cmd.ins_step && !walk_done_reg && (cur_reg != MARK)
                      && (rd_key_reg <= key_in_reg);
    assign ins_stop = cmd.ins_step && !walk_done_reg && !ins_adv;

    // unlink walk: look for the entry whose link points at the target
    assign unl_live = cmd.unl_step && !unl_done_reg;
    assign unl_hit  = rd_link_reg == SW'(tgt_reg);
    assign unl_adv  = unl_live && (rd_link_reg != MARK) && !unl_hit;

    always_comb begin
        if (cmd.ins_start || cmd.unl_start || cmd.rd_head) begin
            rd_addr = head_idx;
        end else if (cmd.addr_slot) begin
            rd_addr = tgt_reg;
        end else if (ins_adv || unl_adv) begin
            rd_addr = to_idx(rd_link_reg);
        end else begin
            rd_addr = to_idx(cur_reg);
        end
    end

    always_comb begin
        link_we = 1'b0;
        link_wa = tgt_reg;
        link_wd = cur_reg;
        if (cmd.link_new) begin
            link_we = 1'b1;
        end else if (cmd.link_prev) begin
            link_we = 1'b1;
            link_wa = to_idx(prev_reg);
            link_wd = SW'(tgt_reg);
        end else if (unl_live && unl_hit) begin
            link_we = 1'b1;
            link_wa = to_idx(cur_reg);
            link_wd = link_s_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_key_reg  <= key_mem[rd_addr];
        rd_pay_reg  <= pay_mem[rd_addr];
        rd_link_reg <= link_mem[rd_addr];
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        if (cmd.link_new) begin
            key_mem[tgt_reg] <= key_in_reg;
        end
        if (cmd.alloc) begin
            pay_mem[tgt_reg] <= pay_in_reg;
        end
    end

    // operand, walk pointer and result registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg    <= func_t'(s_tdata[1:0]);
            key_in_reg  <= s_tdata[33:2];
            pay_in_reg  <= pay_wide[PAYLOAD_BITS-1:0];
            slot_in_reg <= s_tdata[69:66];
        end
        if (cmd.save_link) begin
            link_s_reg <= rd_link_reg;
        end
        if (cmd.ins_start) begin
            cur_reg  <= head_reg;
            prev_reg <= MARK;
        end else if (cmd.unl_start) begin
            cur_reg <= head_reg;
        end else if (ins_adv) begin
            prev_reg <= cur_reg;
            cur_reg  <= rd_link_reg;
        end else if (unl_adv) begin
            cur_reg <= rd_link_reg;
        end
        if (cmd.load_in) begin
            res_ok_reg   <= 1'b0;
            res_slot_reg <= '0;
            res_key_reg  <= '0;
            res_pay_reg  <= '0;
        end else begin
            if (cmd.pop_take) begin
                res_slot_reg <= head_idx;
                res_key_reg  <= rd_key_reg;
                res_pay_reg  <= rd_pay_reg;
            end else if (cmd.alloc) begin
                res_slot_reg <= tgt_reg;
            end
            if (cmd.pop_take || cmd.set_ok) begin
                res_ok_reg <= 1'b1;
            end
        end
        if (cmd.out_load) begin
            out_data_reg <= {6'b0, COUNT_W'(count_reg), res_pay_wide[31:0], res_key_reg,
                             SLOT_W'(res_slot_reg), res_ok_reg};
        end
    end

    // target slot: operand handle, or lowest free slot from the scan
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            tgt_reg <= AW'(s_tdata[69:66]);
        end else if (!free_found_reg && !active_reg[scan_reg]) begin
            tgt_reg <= scan_reg;
        end
        if (cmd.scan_start) begin
            scan_reg <= '0;
        end else if (!free_found_reg && active_reg[scan_reg]) begin
            scan_reg <= scan_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg       <= MARK;
            count_reg      <= '0;
            active_reg     <= '0;
            walk_done_reg  <= 1'b1;
            unl_done_reg   <= 1'b1;
            free_found_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
        end else begin
            // head skip takes the target's link straight from the read port
            if (cmd.pop_take) begin
                head_reg <= rd_link_reg;
            end else if (cmd.head_skip) begin
                head_reg <= rd_link_reg;
            end else if (cmd.link_new && prev_reg == MARK) begin
                head_reg <= SW'(tgt_reg);
            end
            if (cmd.alloc) begin
                count_reg           <= count_reg + 1'b1;
                active_reg[tgt_reg] <= 1'b1;
            end else if (cmd.set_free) begin
                count_reg           <= count_reg - 1'b1;
                active_reg[tgt_reg] <= 1'b0;
            end else if (cmd.pop_take) begin
                count_reg            <= count_reg - 1'b1;
                active_reg[head_idx] <= 1'b0;
            end
            if (cmd.ins_start) begin
                walk_done_reg <= 1'b0;
            end else if (ins_stop) begin
                walk_done_reg <= 1'b1;
            end
            if (cmd.unl_start) begin
                unl_done_reg <= 1'b0;
            end else if (unl_live && !unl_adv) begin
                unl_done_reg <= 1'b1;
            end
            if (cmd.scan_start) begin
                free_found_reg <= 1'b0;
            end else if (!free_found_reg && !active_reg[scan_reg]) begin
                free_found_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        sts.func        = func_reg;
        sts.head_empty  = head_reg == MARK;
        sts.full        = count_reg == MARK;
        sts.slot_ok     = slot_in_range && active_reg[tgt_reg];
        sts.key_same    = rd_key_reg == key_in_reg;
        sts.head_is_tgt = head_reg == SW'(tgt_reg);
        sts.prev_none   = prev_reg == MARK;
        sts.walk_done   = walk_done_reg;
        sts.unl_done    = unl_done_reg;
        sts.free_found  = free_found_reg;
        sts.out_free    = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[sv/sosq_ctrl.sv]
// operation sequencer for the stable ordered slot queue
`timescale 1ns / 1ps

module sosq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  sosq_pkg::sts_t sts,
    output sosq_pkg::cmd_t cmd
);
    import sosq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (sts.func)
                    FUNC_PUSH: begin
                        if (sts.full) begin
                            state_next = ST_FINISH;
                        end else begin
                            cmd.ins_start  = 1'b1;
                            cmd.scan_start = 1'b1;
                            state_next     = ST_INS_WALK;
                        end
                    end
                    FUNC_POP: begin
                        if (sts.head_empty) begin
                            state_next = ST_FINISH;
                        end else begin
                            cmd.rd_head = 1'b1;
                            state_next  = ST_POP_RD;
                        end
                    end
                    default: begin
                        if (!sts.slot_ok) begin
                            state_next = ST_FINISH;
                        end else begin
                            cmd.addr_slot = 1'b1;
                            state_next    = ST_PREP_RD;
                        end
                    end
                endcase
            end
            ST_PREP_RD: begin
                cmd.save_link = 1'b1;
                if (sts.func == FUNC_REORDER && sts.key_same) begin
                    state_next = ST_FINISH;
                end else if (sts.head_is_tgt) begin
                    cmd.head_skip = 1'b1;
                    state_next    = ST_AFTER_UNL;
                end else begin
                    cmd.unl_start = 1'b1;
                    state_next    = ST_UNL_WALK;
                end
            end
            ST_UNL_WALK: begin
                cmd.unl_step = 1'b1;
                if (sts.unl_done) begin
                    state_next = ST_AFTER_UNL;
                end
            end
            ST_AFTER_UNL: begin
                if (sts.func == FUNC_DROP) begin
                    cmd.set_free = 1'b1;
                    cmd.set_ok   = 1'b1;
                    state_next   = ST_FINISH;
                end else begin
                    cmd.ins_start = 1'b1;
                    state_next    = ST_INS_WALK;
                end
            end
            ST_INS_WALK: begin
                cmd.ins_step = 1'b1;
                if (sts.walk_done && sts.free_found) begin
                    state_next = ST_LINK_NEW;
                end
            end
            ST_LINK_NEW: begin
                cmd.link_new = 1'b1;
                cmd.set_ok   = 1'b1;
                cmd.alloc    = sts.func == FUNC_PUSH;
                state_next   = sts.prev_none ? ST_FINISH : ST_LINK_PREV;
            end
            ST_LINK_PREV: begin
                cmd.link_prev = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_POP_RD: begin
                cmd.pop_take = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/stable_ordered_slot_queue.sv]
// top level of the stable ordered slot queue
//
// A pool of POOL_SLOTS slots holds entries (key, payload) on one list sorted by
// ascending key; equal keys stay in arrival order. Each input word carries an
// operation: push, pop, drop or reorder. Each input word gives exactly one
// result word with ok, the slot handle, the popped key and payload, and the
// entry count after the operation.
// One operation is worked at a time. The input is taken into operand registers,
// then a push or reorder walks the list one link per cycle through the registered
// read port of the slot memories; a drop or reorder first walks to find the
// predecessor unless its target is the head. A push scans the active bits for
// the lowest free slot, one bit per cycle, alongside its walk. A reorder to an
// unchanged key ends without changing the list.
// The result sits in an output register, so the next word is taken while it
// waits; if the receiver stalls, the block holds the next result until the
// output register frees. Reset empties the list and the output register.
`timescale 1ns / 1ps
`include "stable_ordered_slot_queue_macros.svh"

module stable_ordered_slot_queue #(
    parameter int POOL_SLOTS   = sosq_pkg::POOL_SLOTS_DEF,
    parameter int PAYLOAD_BITS = sosq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // func[1:0], order_key[33:2], payload[65:34], slot[69:66]
    input  logic [sosq_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // ok[0], slot_out[4:1], order_out[36:5], payload_out[68:37], count[73:69]
    output logic [sosq_pkg::M_TDATA_W-1:0] m_tdata
);
    import sosq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sosq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sosq_datapath #(
        .POOL_SLOTS   (POOL_SLOTS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `SOSQ_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "taken while busy")
    `SOSQ_ASSERT_IMP(a_count_bound, m_tvalid, 32'(m_tdata[73:69]) <= POOL_SLOTS, "count high")
    `SOSQ_ASSERT_IMP(a_fail_clean, m_tvalid && !m_tdata[0], m_tdata[68:1] == '0, "fail not clear")

endmodule
